// ----- sv/mvsd_pkg.sv -----
// shared types and constants of the motion variance sleep detector
package mvsd_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_MIN_NORM    = 3'd0;
   localparam logic [2:0] CSR_SLEEP_LIMIT = 3'd1;
   localparam logic [2:0] CSR_WAKE_LIMIT  = 3'd2;
   localparam logic [2:0] CSR_OBSERVE     = 3'd3;
   localparam logic [2:0] CSR_SLEEP_COUNT = 3'd4;
   localparam logic [2:0] CSR_WAKE_COUNT  = 3'd5;

   // register reset values
   localparam logic [15:0] MIN_NORM_RST    = 16'd2048;
   localparam logic [23:0] SLEEP_LIMIT_RST = 24'd1678;
   localparam logic [23:0] WAKE_LIMIT_RST  = 24'd1678;
   localparam logic [15:0] OBSERVE_RST     = 16'd60000;
   localparam logic [15:0] SLEEP_COUNT_RST = 16'd54000;
   localparam logic [15:0] WAKE_COUNT_RST  = 16'd100;

   localparam int VAR_W = 24;

   // command to the serial multiplier
   typedef struct packed {
      logic start;
      logic clear;
      logic sub;
   } mul_cmd_type;

endpackage

// ----- sv/mvsd_mul.sv -----
// shift-add multiply-accumulate unit, one multiplier bit per cycle
module mvsd_mul #(
   parameter int ACC_W = 44,
   parameter int MP_W  = 22
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mvsd_pkg::mul_cmd_type cmd,
   input  logic [ACC_W-1:0]     mcand,
   input  logic [MP_W-1:0]      mplier,
   output logic                 busy,
   output logic [ACC_W-1:0]     acc
);
   import mvsd_pkg::*;

   logic [ACC_W-1:0] mc_ff, mc_in;
   logic [MP_W-1:0]  mp_ff, mp_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             sub_ff, sub_in;

   // load on start, then add or subtract one shifted partial product a cycle
   always_comb begin
      mc_in  = mc_ff;
      mp_in  = mp_ff;
      acc_in = acc_ff;
      sub_in = sub_ff;
      if (cmd.start) begin
         mc_in  = mcand;
         mp_in  = mplier;
         sub_in = cmd.sub;
         if (cmd.clear) begin
            acc_in = '0;
         end
      end else if (mp_ff != '0) begin
         if (mp_ff[0]) begin
            acc_in = sub_ff ? acc_ff - mc_ff : acc_ff + mc_ff;
         end
         mc_in = {mc_ff[ACC_W-2:0], 1'b0};
         mp_in = {1'b0, mp_ff[MP_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mp_ff <= '0;
      end else begin
         mp_ff <= mp_in;
      end
      mc_ff  <= mc_in;
      acc_ff <= acc_in;
      sub_ff <= sub_in;
   end

   assign busy = (mp_ff != '0);
   assign acc  = acc_ff;

endmodule

// ----- sv/motion_variance_sleep_detector.sv -----
// top level: norm, sliding window, variance and sleep decision
//
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    accel_x, accel_y, accel_z
//  rsp      out        rsp_valid/stall    asleep, variance, evaluated
//  csr      in         csr_valid/ready    csr_index, csr_data
//
// one item at a time; the run per item is data dependent: the shared shift-add
// multiplier takes one multiplier bit per cycle, the root and the divide one bit each.
// reset clears the window fill count, sums, counters and the sleep flag.
// the result register lets a new item in while rsp is stalled.
module motion_variance_sleep_detector #(
   parameter int WINDOW_LEN = 50
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_accel_x,
   input  logic [15:0] req_accel_y,
   input  logic [15:0] req_accel_z,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_asleep,
   output logic [23:0] rsp_variance,
   output logic        rsp_evaluated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);
   import mvsd_pkg::*;

   localparam int LN_W   = $clog2(WINDOW_LEN);
   localparam int SLOT_W = (LN_W < 1) ? 1 : LN_W;
   localparam int FILL_W = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W  = 16 + LN_W;
   localparam int SQS_W  = 32 + LN_W;
   localparam int ACC_W  = 32 + 2 * LN_W;
   localparam int DEN    = WINDOW_LEN * WINDOW_LEN;
   localparam int DEN_W  = $clog2(DEN + 1);

   localparam logic [4:0] ST_IDLE = 5'd0,  ST_SQ_GO = 5'd1,  ST_SQ_WAIT = 5'd2;
   localparam logic [4:0] ST_ROOT = 5'd3,  ST_READ = 5'd4,   ST_NRM_GO = 5'd5;
   localparam logic [4:0] ST_NRM_WAIT = 5'd6, ST_OLD_GO = 5'd7, ST_OLD_WAIT = 5'd8;
   localparam logic [4:0] ST_UPD = 5'd9,  ST_NUM_GO = 5'd10, ST_NUM_WAIT = 5'd11;
   localparam logic [4:0] ST_SUB_GO = 5'd12, ST_SUB_WAIT = 5'd13, ST_DIVSET = 5'd14;
   localparam logic [4:0] ST_DIV = 5'd15, ST_EVAL = 5'd16, ST_DONE = 5'd17;

   // configuration registers
   logic [15:0] min_norm_ff, observe_ticks_ff, sleep_cnt_ff, wake_cnt_ff;
   logic [23:0] sleep_lim_ff, wake_lim_ff;

   // control and datapath registers
   logic [4:0]        state_ff, state_in;
   logic [16:0]       ax_ff, ay_ff, az_ff;
   logic [1:0]        axis_ff, axis_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [31:0]       sq_ff, sq_in;
   logic [16:0]       rem_root_ff, rem_root_in;
   logic [15:0]       root_ff, root_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [23:0]       nsh_ff, nsh_in;
   logic [23:0]       var_ff, var_in;
   logic              eval_ff, eval_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQS_W-1:0]  sqs_ff, sqs_in;
   logic [15:0]       obs_ff, obs_in, quiet_ff, quiet_in, active_ff, active_in;
   logic              sleep_ff, sleep_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_asleep_ff, rsp_eval_ff;
   logic [23:0]       rsp_var_ff;
   logic              rsp_load;

   // window memory
   logic [15:0] win_mem [WINDOW_LEN];
   logic [15:0] rd_ff;
   logic        win_we;

   // multiplier
   mul_cmd_type       cmd;
   logic [ACC_W-1:0]  mcand, acc;
   logic [SUM_W-1:0]  mplier;
   logic              mul_busy;

   mvsd_mul #(.ACC_W(ACC_W), .MP_W(SUM_W)) u_mul (
      .clock(clock), .reset(reset), .cmd(cmd), .mcand(mcand), .mplier(mplier),
      .busy(mul_busy), .acc(acc)
   );

   logic              full;
   logic [15:0]       old_norm;
   logic [16:0]       axis_abs;
   logic [18:0]       root_t, root_trial;
   logic [DEN_W:0]    div_t;
   logic [ACC_W-1:0]  numr;
   logic [16:0]       oc, ac;

   assign full     = (fill_ff == FILL_W'(WINDOW_LEN));
   assign old_norm = full ? rd_ff : 16'd0;
   assign axis_abs = (axis_ff == 2'd0) ? ax_ff : (axis_ff == 2'd1) ? ay_ff : az_ff;
   assign root_t   = {rem_root_ff[16:0], sq_ff[31:30]};
   assign root_trial = {1'b0, root_ff, 2'b01};
   assign div_t    = {rem_ff, nsh_ff[23]};
   assign numr     = acc + ACC_W'(DEN / 2);
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      axis_in     = axis_ff;
      cnt_in      = cnt_ff;
      sq_in       = sq_ff;
      rem_root_in = rem_root_ff;
      root_in     = root_ff;
      rem_in      = rem_ff;
      nsh_in      = nsh_ff;
      var_in      = var_ff;
      eval_in     = eval_ff;
      slot_in     = slot_ff;
      fill_in     = fill_ff;
      sum_in      = sum_ff;
      sqs_in      = sqs_ff;
      obs_in      = obs_ff;
      quiet_in    = quiet_ff;
      active_in   = active_ff;
      sleep_in    = sleep_ff;
      cmd         = '0;
      mcand       = ACC_W'(axis_abs);
      mplier      = SUM_W'(axis_abs);
      win_we      = 1'b0;
      rsp_load    = 1'b0;
      oc          = {1'b0, obs_ff} + 17'd1;
      ac          = {1'b0, active_ff} + 17'd1;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               axis_in  = 2'd0;
               state_in = ST_SQ_GO;
            end
         end
         ST_SQ_GO: begin
            cmd.start = 1'b1;
            cmd.clear = (axis_ff == 2'd0);
            state_in  = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (!mul_busy) begin
               if (axis_ff == 2'd2) begin
                  sq_in       = acc[31:0];
                  rem_root_in = '0;
                  root_in     = '0;
                  cnt_in      = '0;
                  state_in    = ST_ROOT;
               end else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = ST_SQ_GO;
               end
            end
         end
         // one root bit per cycle from two radicand bits
         ST_ROOT: begin
            sq_in = {sq_ff[29:0], 2'b00};
            if (root_t >= root_trial) begin
               rem_root_in = 17'(root_t - root_trial);
               root_in     = {root_ff[14:0], 1'b1};
            end else begin
               rem_root_in = root_t[16:0];
               root_in     = {root_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd15) begin
               state_in = (root_in > min_norm_ff) ? ST_READ : ST_DONE;
               var_in   = '0;
               eval_in  = 1'b0;
            end
         end
         ST_READ: state_in = ST_NRM_GO;
         ST_NRM_GO: begin
            cmd.start = 1'b1;
            cmd.clear = 1'b1;
            mcand     = ACC_W'(root_ff);
            mplier    = SUM_W'(root_ff);
            state_in  = ST_NRM_WAIT;
         end
         ST_NRM_WAIT: if (!mul_busy) state_in = ST_OLD_GO;
         ST_OLD_GO: begin
            cmd.start = 1'b1;
            cmd.sub   = 1'b1;
            mcand     = ACC_W'(old_norm);
            mplier    = SUM_W'(old_norm);
            state_in  = ST_OLD_WAIT;
         end
         ST_OLD_WAIT: if (!mul_busy) state_in = ST_UPD;
         // window write and running sums
         ST_UPD: begin
            win_we = 1'b1;
            sum_in = sum_ff - SUM_W'(old_norm) + SUM_W'(root_ff);
            sqs_in = sqs_ff + acc[SQS_W-1:0];
            slot_in = (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_ff + SLOT_W'(1);
            if (!full) begin
               fill_in = fill_ff + FILL_W'(1);
            end
            state_in = (fill_in == FILL_W'(WINDOW_LEN)) ? ST_NUM_GO : ST_DONE;
         end
         ST_NUM_GO: begin
            cmd.start = 1'b1;
            cmd.clear = 1'b1;
            mcand     = ACC_W'(sqs_ff);
            mplier    = SUM_W'(WINDOW_LEN);
            state_in  = ST_NUM_WAIT;
         end
         ST_NUM_WAIT: if (!mul_busy) state_in = ST_SUB_GO;
         ST_SUB_GO: begin
            cmd.start = 1'b1;
            cmd.sub   = 1'b1;
            mcand     = ACC_W'(sum_ff);
            mplier    = sum_ff;
            state_in  = ST_SUB_WAIT;
         end
         ST_SUB_WAIT: if (!mul_busy) state_in = ST_DIVSET;
         // saturate, else seed the long division
         ST_DIVSET: begin
            eval_in = 1'b1;
            if (numr >= (ACC_W'(DEN) << VAR_W)) begin
               var_in   = '1;
               state_in = ST_EVAL;
            end else begin
               rem_in   = numr[VAR_W +: DEN_W];
               nsh_in   = numr[VAR_W-1:0];
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            nsh_in = {nsh_ff[22:0], 1'b0};
            if (div_t >= (DEN_W+1)'(DEN)) begin
               rem_in = DEN_W'(div_t - (DEN_W+1)'(DEN));
               var_in = {var_ff[22:0], 1'b1};
            end else begin
               rem_in = div_t[DEN_W-1:0];
               var_in = {var_ff[22:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd23) state_in = ST_EVAL;
         end
         // observation, quiet and active counters and the sleep flag
         ST_EVAL: begin
            obs_in = oc[15:0];
            if (!sleep_ff && oc <= {1'b0, observe_ticks_ff} && var_ff < sleep_lim_ff) begin
               if (quiet_ff != 16'hFFFF) quiet_in = quiet_ff + 16'd1;
            end else if (oc > {1'b0, observe_ticks_ff}) begin
               quiet_in = '0;
               obs_in   = '0;
            end
            if (!sleep_ff && quiet_in > sleep_cnt_ff) begin
               sleep_in = 1'b1;
               quiet_in = '0;
            end else if (var_ff >= wake_lim_ff) begin
               if (ac > {1'b0, wake_cnt_ff}) begin
                  sleep_in  = 1'b0;
                  active_in = '0;
                  quiet_in  = '0;
               end else begin
                  active_in = ac[15:0];
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   // window memory, registered read
   always_ff @(posedge clock) begin
      if (win_we) win_mem[slot_ff] <= root_ff;
      rd_ff <= win_mem[slot_ff];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         sqs_ff       <= '0;
         obs_ff       <= '0;
         quiet_ff     <= '0;
         active_ff    <= '0;
         sleep_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         sqs_ff       <= sqs_in;
         obs_ff       <= obs_in;
         quiet_ff     <= quiet_in;
         active_ff    <= active_in;
         sleep_ff     <= sleep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         ax_ff <= req_accel_x[15] ? 17'd0 - {1'b1, req_accel_x} : {1'b0, req_accel_x};
         ay_ff <= req_accel_y[15] ? 17'd0 - {1'b1, req_accel_y} : {1'b0, req_accel_y};
         az_ff <= req_accel_z[15] ? 17'd0 - {1'b1, req_accel_z} : {1'b0, req_accel_z};
      end
      axis_ff     <= axis_in;
      cnt_ff      <= cnt_in;
      sq_ff       <= sq_in;
      rem_root_ff <= rem_root_in;
      root_ff     <= root_in;
      rem_ff      <= rem_in;
      nsh_ff      <= nsh_in;
      var_ff      <= var_in;
      eval_ff     <= eval_in;
      if (rsp_load) begin
         rsp_asleep_ff <= sleep_ff;
         rsp_var_ff    <= var_ff;
         rsp_eval_ff   <= eval_ff;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_norm_ff      <= MIN_NORM_RST;
         sleep_lim_ff     <= SLEEP_LIMIT_RST;
         wake_lim_ff      <= WAKE_LIMIT_RST;
         observe_ticks_ff <= OBSERVE_RST;
         sleep_cnt_ff     <= SLEEP_COUNT_RST;
         wake_cnt_ff      <= WAKE_COUNT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MIN_NORM:    min_norm_ff      <= csr_data[15:0];
            CSR_SLEEP_LIMIT: sleep_lim_ff     <= csr_data;
            CSR_WAKE_LIMIT:  wake_lim_ff      <= csr_data;
            CSR_OBSERVE:     observe_ticks_ff <= csr_data[15:0];
            CSR_SLEEP_COUNT: sleep_cnt_ff     <= csr_data[15:0];
            CSR_WAKE_COUNT:  wake_cnt_ff      <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_asleep    = rsp_asleep_ff;
   assign rsp_variance  = rsp_var_ff;
   assign rsp_evaluated = rsp_eval_ff;

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW_LEN)) else $error("window fill overrun");
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < DEN_W'(DEN)) else $error("divide remainder range");
   a_no_eval_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_eval_ff |-> rsp_var_ff == '0) else $error("variance without eval");
   a_sleep_src: assert property (@(posedge clock) disable iff (reset)
      $rose(sleep_ff) |-> $past(state_ff) == ST_EVAL) else $error("sleep set outside eval");

endmodule
